@@ design/bb3_pkg.sv @@
// shared constants for the 3x3 rgb box blur
`default_nettype none
package bb3_pkg;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned CFG_W_BITS    = 11;
  localparam int unsigned CFG_H_BITS    = 13;
  localparam int unsigned ROW_BITS      = 13;
  localparam int unsigned PIX_BITS      = 24;
  localparam int unsigned SUM_BITS      = 12;
  localparam int unsigned NUM_BITS      = 13;
  localparam int unsigned DEN_BITS      = 5;
  localparam int unsigned CNT_BITS      = 4;
  localparam int unsigned LANES         = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

@@ design/box_blur_3x3_rgb_unit.sv @@
// top level of the 3x3 rgb box blur
`default_nettype none
// Streaming 3x3 box blur of an RGB frame in raster order. Each pixel comes out as the
// round-half-up mean of the neighbours that lie inside the frame, per channel. Results
// lag the input by one row plus one pixel; after the frame's last pixel send
// image_width+1 drain transactions (tuser = 1) to flush the remaining results, the last
// one carrying tlast. A drain sent while pixels are still due is dropped; a pixel sent
// during draining counts as a drain. Two line rams (one read and one write per item)
// hold the previous rows. An item with a result goes through accept, ram read, window
// sum, 13 steps of the bit-serial divider, a step to see it done and output load; a
// stalled output register holds it in output load. Other items go through accept and
// ram read only, a dropped drain accept only. Any register write restarts the frame.
module box_blur_3x3_rgb_unit
  import bb3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // in: red [7:0], green [15:8], blue [23:16]
  input  wire logic [23:0] s_axis_tdata,
  // in: command (1 = drain)
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // out: red [7:0], green [15:8], blue [23:16]
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [CFG_W_BITS-1:0] width_q;
  logic [CFG_H_BITS-1:0] height_q;
  logic [2:0]            state_q, state_d;
  logic [WW-1:0]         in_col_q, out_col_q;
  logic [ROW_BITS-1:0]   in_row_q, out_row_q;
  logic [PIX_BITS-1:0]   pix_q;
  logic [PIX_BITS-1:0]   win_q [9];
  logic [PIX_BITS-1:0]   up_rd, mid_rd;
  logic                  cfg_wr, s_acc, drop, ram_re, ram_we, emit;
  logic [WW-1:0]         eff_w;
  logic [ROW_BITS-1:0]   eff_h;
  logic [2:0]            row_ok, col_ok;
  logic [CNT_BITS-1:0]   cnt;
  logic [SUM_BITS-1:0]   sum [LANES];
  logic [NUM_BITS-1:0]   num [LANES];
  logic [7:0]            quot [LANES];
  logic                  div_start, div_busy, out_load, is_last;
  logic [23:0]           out_data_q;
  logic                  out_last_q, out_valid_q;

  // effective frame size, out-of-range values clamped
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = ROW_BITS'(1);
    end else if (height_q > CFG_H_BITS'(HEIGHT_LIMIT)) begin
      eff_h = ROW_BITS'(HEIGHT_LIMIT);
    end else begin
      eff_h = height_q;
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W_BITS'(1024);
      height_q <= CFG_H_BITS'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[CFG_W_BITS-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_H_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // input handshake; a drain while pixels are still due is dropped
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign drop   = s_axis_tuser[0] && (in_row_q < eff_h);
  assign ram_re = s_acc && !drop;
  assign ram_we = (state_q == ST_READ);

  bb3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q[AW-1:0]),
    .wdata_i (mid_rd),
    .re_i    (ram_re),
    .raddr_i (in_col_q[AW-1:0]),
    .rdata_o (up_rd)
  );

  bb3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q[AW-1:0]),
    .wdata_i (pix_q),
    .re_i    (ram_re),
    .raddr_i (in_col_q[AW-1:0]),
    .rdata_o (mid_rd)
  );

  // result is due once the second row has its second pixel
  assign emit = (in_row_q >= ROW_BITS'(2)) ||
                ((in_row_q == ROW_BITS'(1)) && (in_col_q != '0));

  // neighbourhood masks: window row j is frame row out_row-1+j
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      row_ok[j] = ((out_row_q + (ROW_BITS+2)'(j)) >= (ROW_BITS+2)'(1)) &&
                  ((out_row_q + (ROW_BITS+2)'(j)) <= (ROW_BITS+2)'(eff_h));
      col_ok[j] = ((out_col_q + (WW+2)'(j)) >= (WW+2)'(1)) &&
                  ((out_col_q + (WW+2)'(j)) <= (WW+2)'(eff_w));
    end
    cnt = CNT_BITS'(($countones(row_ok)) * ($countones(col_ok)));
    if (cnt == '0) begin
      cnt = CNT_BITS'(1);
    end
    for (int l = 0; l < LANES; l++) begin
      sum[l] = '0;
      for (int i = 0; i < 9; i++) begin
        if (row_ok[i/3] && col_ok[i%3]) begin
          sum[l] = sum[l] + SUM_BITS'(win_q[i][(2-l)*8 +: 8]);
        end
      end
      num[l] = {sum[l], 1'b0} + NUM_BITS'(cnt);
    end
  end

  assign div_start = (state_q == ST_SUM);

  bb3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   ({cnt, 1'b0}),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign is_last  = (out_row_q == eff_h - 1'b1) && (out_col_q == eff_w - 1'b1);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (ram_re) state_d = ST_READ;
      ST_READ: state_d = emit ? ST_SUM : ST_IDLE;
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  if (!div_busy) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pixel latch; pixels past the frame count as zero
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      pix_q <= (in_row_q < eff_h) ? {s_axis_tdata[7:0], s_axis_tdata[15:8],
                                      s_axis_tdata[23:16]} : '0;
    end
  end

  // window shift and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_wr) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (state_q == ST_READ) begin
        for (int j = 0; j < 3; j++) begin
          win_q[j*3]   <= win_q[j*3+1];
          win_q[j*3+1] <= win_q[j*3+2];
        end
        win_q[2] <= up_rd;
        win_q[5] <= mid_rd;
        win_q[8] <= pix_q;
        if (in_col_q + 1'b1 >= eff_w) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (out_load) begin
        if (is_last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (out_col_q + 1'b1 >= eff_w) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {quot[2], quot[1], quot[0]};
      out_last_q <= is_last;
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tvalid = out_valid_q;

`ifndef ASSERT_OFF
  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q < eff_w) else $error("input column out of range");
  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_col_q < eff_w) else $error("output column out of range");
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy) else $error("divider did not start");
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == ST_READ)) else $error("ram read not consumed");
`endif
endmodule
`default_nettype wire

@@ design/bb3_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module bb3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ design/bb3_div.sv @@
// three lane restoring divider, one quotient bit per cycle
`default_nettype none
module bb3_div
  import bb3_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [NUM_BITS-1:0] num_i [LANES],
  input  wire logic [DEN_BITS-1:0] den_i,
  output logic                     busy_o,
  output logic [7:0]               quot_o [LANES]
);
  localparam int unsigned STEP_W = $clog2(NUM_BITS + 1);

  logic [STEP_W-1:0]   step_q;
  logic [DEN_BITS-1:0] den_q;
  logic [NUM_BITS-1:0] n_q [LANES];
  logic [NUM_BITS-1:0] quo_q [LANES];
  logic [DEN_BITS:0]   rem_q [LANES];
  logic [DEN_BITS:0]   trial [LANES];
  logic                fit [LANES];

  assign busy_o = (step_q != '0);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l]  = {rem_q[l][DEN_BITS-1:0], n_q[l][NUM_BITS-1]};
      fit[l]    = (trial[l] >= {1'b0, den_q});
      quot_o[l] = quo_q[l][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(NUM_BITS);
    end else if (busy_o) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      for (int l = 0; l < LANES; l++) begin
        n_q[l]   <= num_i[l];
        rem_q[l] <= '0;
        quo_q[l] <= '0;
      end
    end else if (busy_o) begin
      for (int l = 0; l < LANES; l++) begin
        n_q[l]   <= {n_q[l][NUM_BITS-2:0], 1'b0};
        rem_q[l] <= fit[l] ? (trial[l] - {1'b0, den_q}) : trial[l];
        quo_q[l] <= {quo_q[l][NUM_BITS-2:0], fit[l]};
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/box_blur_3x3_rgb_unit_tb.sv @@
// testbench for the 3x3 rgb box blur: directed and randomized frames checked against a behavioral predictor
`timescale 1ns / 100ps
module box_blur_3x3_rgb_unit_tb
  import bb3_pkg::*;
();

  localparam int unsigned MAXW = 1024;

  // one expected output pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_px_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_blur_3x3_rgb_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [10:0] cfg_width = 11'd1024;
  logic [12:0] cfg_height = 13'd1;
  logic [23:0] line_up [MAXW];
  logic [23:0] line_mid [MAXW];
  logic [23:0] win [9];
  int unsigned in_col, in_row, out_col, out_row;

  blur_px_t expected_px[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off = 0;   // cycles the receiver refuses outright
  int unsigned pixels_out = 0;

  function automatic int unsigned eff_w();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAXW) return MAXW;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_h();
    if (cfg_height == 0) return 1;
    if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return cfg_height;
  endfunction

  // advance the blur predictor by one accepted transaction
  task automatic predict_blur(input logic drain, input logic [23:0] data);
    int unsigned w, h, col, cnt, r, c;
    int unsigned sum [3];
    logic [23:0] px, v;
    logic emits, fin;
    blur_px_t e;
    w = eff_w();
    h = eff_h();
    // tdata holds red low, blue high; the store packs red high like the window
    if (in_row < h) begin
      if (drain) return;
      px = {data[7:0], data[15:8], data[23:16]};
    end else begin
      px = '0;
    end
    col = (in_col >= MAXW) ? MAXW - 1 : in_col;
    for (int j = 0; j < 3; j++) begin
      win[j*3] = win[j*3+1];
      win[j*3+1] = win[j*3+2];
    end
    win[2] = line_up[col];
    win[5] = line_mid[col];
    win[8] = px;
    line_up[col] = line_mid[col];
    line_mid[col] = px;
    emits = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emits) return;
    sum = '{0, 0, 0};
    cnt = 0;
    for (int j = 0; j < 3; j++) begin
      r = out_row + j;
      if (r < 1 || r > h) continue;
      for (int k = 0; k < 3; k++) begin
        c = out_col + k;
        if (c < 1 || c > w) continue;
        v = win[j*3+k];
        sum[0] += v[23:16];
        sum[1] += v[15:8];
        sum[2] += v[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    e.red = 8'((2*sum[0] + cnt) / (2*cnt));
    e.green = 8'((2*sum[1] + cnt) / (2*cnt));
    e.blue = 8'((2*sum[2] + cnt) / (2*cnt));
    fin = (out_row == h - 1) && (out_col == w - 1);
    e.last = fin;
    expected_px.push_back(e);
    if (fin) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output checker, one transaction per handshake
  always @(posedge clk_i) begin
    blur_px_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pixels_out++;
      if (expected_px.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_px.pop_front();
        if (m_axis_tdata[7:0] !== e.red)
          report_mismatch($sformatf("red %0h exp %0h", m_axis_tdata[7:0], e.red));
        if (m_axis_tdata[15:8] !== e.green)
          report_mismatch($sformatf("green %0h exp %0h", m_axis_tdata[15:8], e.green));
        if (m_axis_tdata[23:16] !== e.blue)
          report_mismatch($sformatf("blue %0h exp %0h", m_axis_tdata[23:16], e.blue));
        if (m_axis_tlast !== e.last)
          report_mismatch($sformatf("tlast %0b exp %0b", m_axis_tlast, e.last));
      end
    end
  end

  // one transaction into the block; valid stays high across back-to-back items
  task automatic send_item(input logic drain, input logic [23:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= drain;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_blur(drain, data);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // register write while idle; also restarts the frame
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) cfg_width = value[10:0];
    else if (addr == 3'd4) cfg_height = value[12:0];
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // whole frame followed by width+1 drains; noise drains mid-frame if asked
  task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
    int unsigned weff, heff;
    write_reg(3'd0, w);
    write_reg(3'd4, h);
    weff = eff_w();
    heff = eff_h();
    for (int unsigned i = 0; i < weff * heff; i++) begin
      if (noisy && $urandom_range(9) == 0) send_item(1'b1, 24'($urandom));
      send_item(1'b0, rand_pixel());
    end
    for (int unsigned i = 0; i <= weff; i++)
      send_item(1'($urandom_range(1)), 24'($urandom));
    wait_drained();
  endtask

  // directed: single pixel, single row, single column, extreme values
  task automatic test_directed();
    write_reg(3'd0, 32'd1); write_reg(3'd4, 32'd1);
    send_item(1'b1, 24'h123456);          // drain before pixel is dropped
    send_item(1'b0, 24'hffffff);
    send_item(1'b0, 24'h00ff00);          // pixel during draining acts as drain
    send_item(1'b1, 24'h0);
    wait_drained();
    send_frame(3, 1, 1'b0);
    send_frame(1, 3, 1'b0);
    send_frame(2, 2, 1'b0);
  endtask

  // register range extremes: zero and above-max widths/heights
  task automatic test_reg_extremes();
    write_reg(3'd0, 32'd0); write_reg(3'd4, 32'd0);
    send_item(1'b0, 24'haaaaaa); send_item(1'b1, 24'h0); send_item(1'b1, 24'h0);
    wait_drained();
    // width clamps to the full line; the first results cross the row wrap
    write_reg(3'd0, 32'h7ff); write_reg(3'd4, 32'd2);
    for (int i = 0; i < MAXW + 3; i++) send_item(1'b0, rand_pixel());
    wait_drained();
    write_reg(3'd0, 32'd2); write_reg(3'd4, 32'h1fff);   // height clamps to 4096
    for (int i = 0; i < 40; i++) send_item(1'b0, rand_pixel());
    wait_drained();
    write_reg(3'd0, 32'd4); write_reg(3'd4, 32'd4);
    write_reg(3'd0, 32'd4);   // restart mid-frame case is idle here but still clears
    send_frame(4, 3, 1'b1);
  endtask

  // randomized frames under one idling profile
  task automatic test_random(input int unsigned idle, input int unsigned stall,
                             input int unsigned frames);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned f = 0; f < frames; f++)
      send_frame($urandom_range(1, 9), $urandom_range(1, 6), 1'($urandom_range(1)));
  endtask

  // long receiver hold-off while input keeps flowing, then a full pause
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(3'd0, 32'd8); write_reg(3'd4, 32'd8);
    @(posedge clk_i);
    hold_off = 600;
    for (int i = 0; i < 64; i++) send_item(1'b0, rand_pixel());
    for (int i = 0; i <= 8; i++) send_item(1'b1, 24'h0);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reg_extremes();
    test_random(0, 0, 2);
    test_random(71, 0, 2);
    test_random(0, 71, 2);
    test_random(34, 34, 2);
    test_backpressure();
    test_random(0, 0, 1);
    wait_drained();
    if (errors == 0 && expected_px.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/bb3_pkg.sv
design/bb3_ram.sv
design/bb3_div.sv
design/box_blur_3x3_rgb_unit.sv
tb/sv/box_blur_3x3_rgb_unit_tb.sv
